FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL of the cartridge bank-switch map.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/cbsm_pkg.sv
// Shared types, codes and address constants for the cartridge bank-switch map.
// No dependencies; imported by the top level.
package cbsm_pkg;

  // Port widths
  localparam int ADDR_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int KIND_W    = 2;
  localparam int REGION_W  = 2;
  localparam int SCHEME_W  = 3;
  localparam int UNITS_W   = 4;
  localparam int BANK_W    = 2;
  localparam int SLICE_W   = 3;
  localparam int OFF_W     = 12;
  localparam int ROM_IDX_W = 14;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 4;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  // Console RAM is fixed by the bus map
  localparam int CONS_RAM_BYTES = 128;
  localparam int CONS_AW        = 7;

  // Access kinds
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd2;

  // Result regions
  localparam logic [REGION_W-1:0] REGION_LOCAL = 2'd0;
  localparam logic [REGION_W-1:0] REGION_VIDEO = 2'd1;
  localparam logic [REGION_W-1:0] REGION_IO    = 2'd2;

  // Bank schemes
  localparam logic [SCHEME_W-1:0] SCHEME_PLAIN = 3'd0;
  localparam logic [SCHEME_W-1:0] SCHEME_F8    = 3'd1;
  localparam logic [SCHEME_W-1:0] SCHEME_F6    = 3'd2;
  localparam logic [SCHEME_W-1:0] SCHEME_F6SC  = 3'd3;
  localparam logic [SCHEME_W-1:0] SCHEME_E0    = 3'd4;
  localparam logic [SCHEME_W-1:0] SCHEME_FA    = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCHEME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNITS  = 2'd1;

  // Bus address decode
  localparam logic [ADDR_W-1:0] VIDEO_MASK  = 16'h1080;
  localparam logic [ADDR_W-1:0] PERIPH_MASK = 16'h1280;
  localparam logic [ADDR_W-1:0] PERIPH_RAM  = 16'h0080;
  localparam logic [ADDR_W-1:0] PERIPH_IO   = 16'h0280;

  // Cartridge window offsets
  localparam logic [OFF_W-1:0] HOT_BASE   = 12'hf80;
  localparam logic [OFF_W-1:0] F8_BANK0   = 12'hff8;
  localparam logic [OFF_W-1:0] F8_BANK1   = 12'hff9;
  localparam logic [OFF_W-1:0] F6_FIRST   = 12'hff6;
  localparam logic [OFF_W-1:0] F6_LAST    = 12'hff9;
  localparam logic [OFF_W-1:0] FA_FIRST   = 12'hff8;
  localparam logic [OFF_W-1:0] FA_LAST    = 12'hffa;
  localparam logic [OFF_W-1:0] E0_S0_LO   = 12'hfe0;
  localparam logic [OFF_W-1:0] E0_S1_LO   = 12'hfe8;
  localparam logic [OFF_W-1:0] E0_S2_LO   = 12'hff0;
  localparam logic [OFF_W-1:0] E0_S2_HI   = 12'hff7;
  localparam logic [OFF_W-1:0] FA_RAM_END = 12'h200;
  localparam logic [OFF_W-1:0] FA_RD_BASE = 12'h100;
  localparam logic [OFF_W-1:0] SC_RAM_END = 12'h100;
  localparam logic [OFF_W-1:0] SC_RD_BASE = 12'h080;
  localparam logic [SLICE_W-1:0] E0_FIXED = 3'd7;

  // Where a read result comes from
  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_ROM,
    SRC_CRAM,
    SRC_CONS
  } src_t;

  // Last whole 4K bank for a ROM size in 2K units (0 treated as 1, above 8 as 8)
  function automatic logic [BANK_W-1:0] last_bank(input logic [UNITS_W-1:0] units);
    logic [UNITS_W-1:0] u;
    logic [UNITS_W-1:0] d;
    begin
      u = units;
      if (u > 4'd8) begin
        u = 4'd8;
      end
      if (u < 4'd2) begin
        d = '0;
      end else begin
        d = (u - 4'd2) >> 1;
      end
      last_bank = d[BANK_W-1:0];
    end
  endfunction

endpackage

FILE: sv/cbsm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module cbsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/cartridge_bank_switch_map.sv
// Top level of the cartridge bank-switch map: bus decode, mappers, ROM and RAMs.
// Depends on cbsm_pkg, cbsm_ram and assert_macros.svh.
//
//  channel | signals                          | beat
//  --------+----------------------------------+-----------------------------------
//  in      | in_tvalid/in_tready/tdata/tuser  | one bus access or ROM load byte
//  out     | out_tvalid/out_tready/tdata/tuser| one result per input beat
//  cfg     | cfg_valid/cfg_ready/index/data   | one register write, always ready
//
// One beat is accepted every cycle while in_tready is high; each result passes through
// the read stage, for the registered memory read, and then the output register.
// Bank and slice registers are updated at the accept edge, so the next beat sees them.
// Reset (rst_n low at a clock edge) clears valid bits of both RAMs, the mapper
// state and the pipeline; ROM contents are kept. A stalled output holds one result
// in the output register and one in the read stage, then in_tready drops.
`include "assert_macros.svh"

module cartridge_bank_switch_map #(
  parameter int CART_BYTES     = 16384,
  parameter int CART_RAM_BYTES = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: address[15:0], write_data[23:16]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [cbsm_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: kind[1:0]
  input  logic [cbsm_pkg::KIND_W-1:0]       in_tuser,
  // out_tdata: read_data[7:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cbsm_pkg::OUT_DATA_W-1:0]   out_tdata,
  // out_tuser: region[1:0]
  output logic [cbsm_pkg::REGION_W-1:0]     out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cbsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cbsm_pkg::CFG_DAT_W-1:0]    cfg_data
);

  import cbsm_pkg::*;

  localparam int ROM_AW  = $clog2(CART_BYTES);
  localparam int CRAM_AW = $clog2(CART_RAM_BYTES);

  // Configuration and mapper state
  logic [SCHEME_W-1:0] scheme_r;
  logic [UNITS_W-1:0]  units_r;
  logic [BANK_W-1:0]   rom_bank_r;
  logic [BANK_W-1:0]   rom_bank_nxt;
  logic [SLICE_W-1:0]  slice_r   [3];
  logic [SLICE_W-1:0]  slice_nxt [3];

  // Input fields
  logic                acc;
  logic [KIND_W-1:0]   kind;
  logic [ADDR_W-1:0]   addr;
  logic [BYTE_W-1:0]   wdata;
  logic [OFF_W-1:0]    off;
  logic                is_wr;

  // Decode results
  src_t                src;
  logic [REGION_W-1:0] region;
  logic                rom_rd;
  logic                rom_wr;
  logic                cram_rd;
  logic                cram_wr;
  logic                cons_rd;
  logic                cons_wr;
  logic [ROM_IDX_W-1:0] rom_idx;
  logic                rom_ok;
  logic                load_ok;
  logic [BYTE_W-1:0]   cram_idx;
  logic                cram_ok;
  logic                mirror;
  logic [OFF_W-1:0]    rom_off;
  logic [1:0]          part;
  logic [SLICE_W-1:0]  slice_sel;
  logic [OFF_W-1:0]    f6_diff;

  // Valid bits of the two cleared RAMs
  logic [CONS_RAM_BYTES-1:0] cons_vld_r;
  logic [CART_RAM_BYTES-1:0] cram_vld_r;

  // Read stage and output register
  logic                s1_valid_r;
  src_t                s1_src_r;
  logic                s1_hit_r;
  logic [REGION_W-1:0] s1_region_r;
  logic                s1_adv;
  logic                out_valid_r;
  logic [BYTE_W-1:0]   out_data_r;
  logic [REGION_W-1:0] out_region_r;
  logic [BYTE_W-1:0]   out_data_nxt;

  logic [BYTE_W-1:0]   rom_q;
  logic [BYTE_W-1:0]   cram_q;
  logic [BYTE_W-1:0]   cons_q;

  assign kind  = in_tuser;
  assign addr  = in_tdata[15:0];
  assign wdata = in_tdata[23:16];
  assign off   = addr[OFF_W-1:0];
  assign is_wr = (kind == KIND_WRITE);

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign acc       = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Hotspot decode: bank and slice values this beat leaves behind
  assign f6_diff = off - F6_FIRST;
  always_comb begin
    rom_bank_nxt = rom_bank_r;
    slice_nxt    = slice_r;
    if ((kind == KIND_READ || kind == KIND_WRITE) &&
        (addr & VIDEO_MASK) != '0 &&
        (addr & PERIPH_MASK) != PERIPH_RAM &&
        (addr & PERIPH_MASK) != PERIPH_IO &&
        off >= HOT_BASE) begin
      case (scheme_r)
        SCHEME_F8: begin
          if (off == F8_BANK0) begin
            rom_bank_nxt = 2'd0;
          end else if (off == F8_BANK1) begin
            rom_bank_nxt = 2'd1;
          end
        end
        SCHEME_F6, SCHEME_F6SC: begin
          if (off >= F6_FIRST && off <= F6_LAST) begin
            rom_bank_nxt = f6_diff[BANK_W-1:0];
          end
        end
        SCHEME_E0: begin
          if (off >= E0_S0_LO && off < E0_S1_LO) begin
            slice_nxt[0] = off[SLICE_W-1:0];
          end else if (off >= E0_S1_LO && off < E0_S2_LO) begin
            slice_nxt[1] = off[SLICE_W-1:0];
          end else if (off >= E0_S2_LO && off <= E0_S2_HI) begin
            slice_nxt[2] = off[SLICE_W-1:0];
          end
        end
        SCHEME_FA: begin
          if (off >= FA_FIRST && off <= FA_LAST) begin
            rom_bank_nxt = off[BANK_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ROM index through the mapping as it stands after this beat's hotspot
  assign mirror    = (units_r <= 4'd1);
  assign part      = off[11:10];
  assign slice_sel = (part == 2'd3) ? E0_FIXED : slice_nxt[part];
  assign rom_off   = mirror ? {1'b0, off[10:0]} : off;
  always_comb begin
    if (scheme_r == SCHEME_E0) begin
      rom_idx = {1'b0, slice_sel, off[9:0]};
    end else begin
      rom_idx = {rom_bank_nxt, rom_off};
    end
  end
  assign rom_ok  = ({1'b0, rom_idx} < 15'(CART_BYTES));
  assign load_ok = ({1'b0, addr} < 17'(CART_BYTES));

  // Cartridge RAM index for the two RAM schemes
  assign cram_idx = (scheme_r == SCHEME_FA) ? off[7:0] : {1'b0, off[6:0]};
  assign cram_ok  = ({1'b0, cram_idx} < 9'(CART_RAM_BYTES));

  // Bus decode: pick region, memory ports and read source
  always_comb begin
    src     = SRC_ZERO;
    region  = REGION_LOCAL;
    rom_rd  = 1'b0;
    rom_wr  = 1'b0;
    cram_rd = 1'b0;
    cram_wr = 1'b0;
    cons_rd = 1'b0;
    cons_wr = 1'b0;
    if (kind == KIND_LOAD) begin
      rom_wr = load_ok;
    end else if (kind == KIND_READ || kind == KIND_WRITE) begin
      if ((addr & VIDEO_MASK) == '0) begin
        region = REGION_VIDEO;
      end else if ((addr & PERIPH_MASK) == PERIPH_RAM) begin
        if (is_wr) begin
          cons_wr = 1'b1;
        end else begin
          cons_rd = 1'b1;
          src     = SRC_CONS;
        end
      end else if ((addr & PERIPH_MASK) == PERIPH_IO) begin
        region = REGION_IO;
      end else if (off >= HOT_BASE ||
                   !((scheme_r == SCHEME_FA && off < FA_RAM_END) ||
                     (scheme_r == SCHEME_F6SC && off < SC_RAM_END))) begin
        // Plain ROM window; writes only act through hotspots
        if (!is_wr) begin
          rom_rd = rom_ok;
          src    = rom_ok ? SRC_ROM : SRC_ZERO;
        end
      end else if ((scheme_r == SCHEME_FA && off < FA_RD_BASE) ||
                   (scheme_r == SCHEME_F6SC && off < SC_RD_BASE)) begin
        // RAM write window; reads here see ROM
        if (is_wr) begin
          cram_wr = cram_ok;
        end else begin
          rom_rd = rom_ok;
          src    = rom_ok ? SRC_ROM : SRC_ZERO;
        end
      end else if (!is_wr) begin
        // RAM read window
        cram_rd = cram_ok;
        src     = cram_ok ? SRC_CRAM : SRC_ZERO;
      end
    end
  end

  // Memories
  cbsm_ram #(.WIDTH(BYTE_W), .DEPTH(CART_BYTES)) u_rom (
    .clk     (clk),
    .wr_en   (acc && rom_wr),
    .wr_addr (addr[ROM_AW-1:0]),
    .wr_data (wdata),
    .rd_en   (acc && rom_rd),
    .rd_addr (rom_idx[ROM_AW-1:0]),
    .rd_data (rom_q)
  );

  cbsm_ram #(.WIDTH(BYTE_W), .DEPTH(CART_RAM_BYTES)) u_cram (
    .clk     (clk),
    .wr_en   (acc && cram_wr),
    .wr_addr (cram_idx[CRAM_AW-1:0]),
    .wr_data (wdata),
    .rd_en   (acc && cram_rd),
    .rd_addr (cram_idx[CRAM_AW-1:0]),
    .rd_data (cram_q)
  );

  cbsm_ram #(.WIDTH(BYTE_W), .DEPTH(CONS_RAM_BYTES)) u_cons (
    .clk     (clk),
    .wr_en   (acc && cons_wr),
    .wr_addr (addr[CONS_AW-1:0]),
    .wr_data (wdata),
    .rd_en   (acc && cons_rd),
    .rd_addr (addr[CONS_AW-1:0]),
    .rd_data (cons_q)
  );

  // Config and mapper state; user must send config writes only while idle, not enforced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scheme_r   <= SCHEME_PLAIN;
      units_r    <= 4'd2;
      rom_bank_r <= last_bank(4'd2);
      slice_r[0] <= 3'd0;
      slice_r[1] <= 3'd1;
      slice_r[2] <= 3'd2;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_SCHEME) begin
        scheme_r <= cfg_data[SCHEME_W-1:0];
      end else if (cfg_index == CFG_UNITS) begin
        units_r    <= cfg_data;
        rom_bank_r <= last_bank(cfg_data);
      end
    end else if (acc) begin
      rom_bank_r <= rom_bank_nxt;
      slice_r    <= slice_nxt;
    end
  end

  // Mark RAM entries once written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cons_vld_r <= '0;
      cram_vld_r <= '0;
    end else begin
      if (acc && cons_wr) begin
        cons_vld_r[addr[CONS_AW-1:0]] <= 1'b1;
      end
      if (acc && cram_wr) begin
        cram_vld_r[cram_idx[CRAM_AW-1:0]] <= 1'b1;
      end
    end
  end

  // Read stage: hold the beat while its memory read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_src_r    <= src;
      s1_region_r <= region;
      s1_hit_r    <= (src == SRC_CONS) ? cons_vld_r[addr[CONS_AW-1:0]]
                                       : cram_vld_r[cram_idx[CRAM_AW-1:0]];
    end
  end

  // Select read data; a RAM entry never written reads as zero
  always_comb begin
    case (s1_src_r)
      SRC_ROM:  out_data_nxt = rom_q;
      SRC_CRAM: out_data_nxt = s1_hit_r ? cram_q : '0;
      SRC_CONS: out_data_nxt = s1_hit_r ? cons_q : '0;
      default:  out_data_nxt = '0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r   <= out_data_nxt;
      out_region_r <= s1_region_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_region_r;

  // Checks
  `ASSERT_SAME(a_ext_zero, out_tvalid && out_tuser != REGION_LOCAL, out_tdata == '0,
               "external region result carries nonzero data")
  `ASSERT_NEXT(a_write_no_src, acc && kind == KIND_WRITE, s1_src_r == SRC_ZERO,
               "bus write selected a read source")
  `ASSERT_NEXT(a_s1_hold, s1_valid_r && !s1_adv, s1_valid_r,
               "read stage dropped a stalled beat")

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the cartridge bank-switch map.
// Uses cbsm_pkg and the cartridge_bank_switch_map top level. A scoreboard class
// predicts every access and checks results in order.
`timescale 1ns / 1ps

module testbench;
  import cbsm_pkg::*;

  localparam int CART_BYTES     = 16384;
  localparam int CART_RAM_BYTES = 256;

  // Scheme and kind codes that the package leaves unnamed
  localparam logic [SCHEME_W-1:0] SCHEME_SPARE_LO = 3'd6;
  localparam logic [SCHEME_W-1:0] SCHEME_SPARE_HI = 3'd7;
  localparam logic [KIND_W-1:0]   KIND_SPARE      = 2'd3;

  localparam int PHASES       = 12;
  localparam int PHASE_BEATS  = 85;
  localparam int QUIET_PHASE  = 10;

  // One predicted result, with the access that caused it
  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   addr;
    logic [BYTE_W-1:0]   rd;
    logic [REGION_W-1:0] region;
  } bus_result_t;

  // Bus map predictor and in-order result checker
  class bus_map_model;
    logic [BYTE_W-1:0]   rom_image   [CART_BYTES];
    bit                  rom_loaded  [CART_BYTES];
    logic [BYTE_W-1:0]   console_ram [CONS_RAM_BYTES];
    logic [BYTE_W-1:0]   cart_ram    [CART_RAM_BYTES];
    logic [SCHEME_W-1:0] scheme;
    logic [UNITS_W-1:0]  units;
    logic [BANK_W-1:0]   bank;
    logic [SLICE_W-1:0]  slice_sel [3];
    bus_result_t         owed [$];
    int                  errors;

    function new();
      foreach (rom_image[i]) rom_image[i] = '0;
      foreach (rom_loaded[i]) rom_loaded[i] = 1'b0;
      foreach (console_ram[i]) console_ram[i] = '0;
      foreach (cart_ram[i]) cart_ram[i] = '0;
      scheme       = SCHEME_PLAIN;
      units        = 4'd2;
      bank         = top_bank();
      slice_sel[0] = 3'd0;
      slice_sel[1] = 3'd1;
      slice_sel[2] = 3'd2;
      errors       = 0;
    endfunction

    function logic [UNITS_W-1:0] clamped_units();
      if (units == 4'd0) return 4'd1;
      if (units > 4'd8) return 4'd8;
      return units;
    endfunction

    // Last whole 4K bank of the configured size
    function logic [BANK_W-1:0] top_bank();
      logic [UNITS_W-1:0] u;
      logic [UNITS_W-1:0] d;
      u = clamped_units();
      if (u < 4'd2) return '0;
      d = (u - 4'd2) >> 1;
      return d[BANK_W-1:0];
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      if (idx == CFG_SCHEME) begin
        scheme = val[SCHEME_W-1:0];
      end else if (idx == CFG_UNITS) begin
        units = val;
        bank  = top_bank();
      end
    endfunction

    function logic [BYTE_W-1:0] rom_byte(int unsigned idx);
      if (idx >= CART_BYTES) return '0;
      return rom_image[idx];
    endfunction

    // ROM index behind an offset of the 4K cartridge window
    function int unsigned window_index(logic [OFF_W-1:0] off);
      logic [OFF_W-1:0]   o;
      logic [SLICE_W-1:0] sl;
      if (scheme == SCHEME_E0) begin
        sl = (off[11:10] == 2'd3) ? E0_FIXED : slice_sel[off[11:10]];
        return 32'({sl, off[9:0]});
      end
      o = off;
      // mirror a 2K image over the window
      if (clamped_units() <= 4'd1) o[11] = 1'b0;
      return 32'({bank, o});
    endfunction

    // Read the 4K cartridge window through the current mapping
    function logic [BYTE_W-1:0] window(logic [OFF_W-1:0] off);
      return rom_byte(window_index(off));
    endfunction

    // Bank and slice switching on the top area of the window
    function void switch_bank(logic [OFF_W-1:0] off);
      logic [OFF_W-1:0] d;
      case (scheme)
        SCHEME_F8: begin
          if (off == F8_BANK0) bank = 2'd0;
          else if (off == F8_BANK1) bank = 2'd1;
        end
        SCHEME_F6, SCHEME_F6SC: begin
          if (off >= F6_FIRST && off <= F6_LAST) begin
            d    = off - F6_FIRST;
            bank = d[BANK_W-1:0];
          end
        end
        SCHEME_E0: begin
          if (off >= E0_S0_LO && off < E0_S1_LO) slice_sel[0] = off[2:0];
          else if (off >= E0_S1_LO && off < E0_S2_LO) slice_sel[1] = off[2:0];
          else if (off >= E0_S2_LO && off <= E0_S2_HI) slice_sel[2] = off[2:0];
        end
        SCHEME_FA: begin
          if (off >= FA_FIRST && off <= FA_LAST) begin
            d    = off - FA_FIRST;
            bank = d[BANK_W-1:0];
          end
        end
        default: ;
      endcase
    endfunction

    // True when a bus read would reach a ROM byte that was never loaded
    function bit needs_load(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                            output int unsigned idx);
      logic [BANK_W-1:0]  bank_keep;
      logic [SLICE_W-1:0] slice_keep [3];
      logic [OFF_W-1:0]   off;
      off = addr[OFF_W-1:0];
      idx = 0;
      if (kind != KIND_READ) return 1'b0;
      if ((addr & VIDEO_MASK) == '0 || (addr & PERIPH_MASK) == PERIPH_RAM ||
          (addr & PERIPH_MASK) == PERIPH_IO) return 1'b0;
      if (scheme == SCHEME_FA && off >= FA_RD_BASE && off < FA_RAM_END) return 1'b0;
      if (scheme == SCHEME_F6SC && off >= SC_RD_BASE && off < SC_RAM_END) return 1'b0;
      // look at the mapping the access itself leaves behind, then restore it
      bank_keep  = bank;
      slice_keep = slice_sel;
      if (off >= HOT_BASE) switch_bank(off);
      idx       = window_index(off);
      bank      = bank_keep;
      slice_sel = slice_keep;
      return (idx < CART_BYTES) && !rom_loaded[idx];
    endfunction

    // Apply one accepted access and queue the result it owes
    function void note_access(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                              logic [BYTE_W-1:0] wdata);
      bus_result_t      r;
      logic [OFF_W-1:0] off;
      logic             wr;
      r.kind   = kind;
      r.addr   = addr;
      r.rd     = '0;
      r.region = REGION_LOCAL;
      wr       = (kind == KIND_WRITE);
      off      = addr[OFF_W-1:0];
      if (kind == KIND_LOAD) begin
        if (addr < CART_BYTES) begin
          rom_image[addr[ROM_IDX_W-1:0]]  = wdata;
          rom_loaded[addr[ROM_IDX_W-1:0]] = 1'b1;
        end
      end else if (kind == KIND_READ || wr) begin
        if ((addr & VIDEO_MASK) == '0) begin
          r.region = REGION_VIDEO;
        end else if ((addr & PERIPH_MASK) == PERIPH_RAM) begin
          if (wr) console_ram[addr[CONS_AW-1:0]] = wdata;
          else r.rd = console_ram[addr[CONS_AW-1:0]];
        end else if ((addr & PERIPH_MASK) == PERIPH_IO) begin
          r.region = REGION_IO;
        end else if (off >= HOT_BASE) begin
          switch_bank(off);
          if (!wr) r.rd = window(off);
        end else if (scheme == SCHEME_FA && off < FA_RAM_END) begin
          if (off < FA_RD_BASE) begin
            if (wr) cart_ram[off[7:0]] = wdata;
            else r.rd = window(off);
          end else if (!wr) begin
            r.rd = cart_ram[off[7:0]];
          end
        end else if (scheme == SCHEME_F6SC && off < SC_RAM_END) begin
          if (off < SC_RD_BASE) begin
            if (wr) cart_ram[off[6:0]] = wdata;
            else r.rd = window(off);
          end else if (!wr) begin
            r.rd = cart_ram[off[6:0]];
          end
        end else if (!wr) begin
          r.rd = window(off);
        end
      end
      owed.push_back(r);
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("%0t: %s", $time, what);
    endfunction

    // Compare one result beat with the oldest prediction
    function void check_result(logic [BYTE_W-1:0] rd, logic [REGION_W-1:0] region);
      bus_result_t r;
      if (owed.size() == 0) begin
        flag($sformatf("result rd %02h region %0d with no access outstanding", rd, region));
        return;
      end
      r = owed.pop_front();
      if (rd !== r.rd || region !== r.region)
        flag($sformatf("kind %0d addr %04h: expected rd %02h region %0d, got rd %02h region %0d",
                       r.kind, r.addr, r.rd, r.region, rd, region));
    endfunction

    function void close_out();
      if (owed.size() != 0) flag($sformatf("%0d results never arrived", owed.size()));
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [KIND_W-1:0]     in_tuser   = KIND_READ;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [REGION_W-1:0]   out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = CFG_SCHEME;
  logic [CFG_DAT_W-1:0]  cfg_data   = '0;

  bus_map_model sb = new();
  bit           idle_on = 1'b1;
  int unsigned  sent    = 0;

  cartridge_bank_switch_map #(
    .CART_BYTES     (CART_BYTES),
    .CART_RAM_BYTES (CART_RAM_BYTES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // Stall the result side in short bursts
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // Offer one access beat and hold it until taken
  task automatic put_beat(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                          logic [BYTE_W-1:0] wdata);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {wdata, addr};
    do @(posedge clk); while (!in_tready);
    sb.note_access(kind, addr, wdata);
    sent++;
  endtask

  // Load the ROM byte a read would reach first if it was never loaded
  task automatic send_beat(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                           logic [BYTE_W-1:0] wdata);
    int unsigned idx;
    if (sb.needs_load(kind, addr, idx)) put_beat(KIND_LOAD, 16'(idx), 8'($urandom));
    put_beat(kind, addr, wdata);
  endtask

  // Hold the sender until every owed result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  // Write both registers while the block is idle
  task automatic reconfigure(logic [SCHEME_W-1:0] scheme, logic [UNITS_W-1:0] units);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SCHEME;
    cfg_data  <= {1'b0, scheme};
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(CFG_SCHEME, {1'b0, scheme});
    cfg_index <= CFG_UNITS;
    cfg_data  <= units;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(CFG_UNITS, units);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [ADDR_W-1:0] cart_addr(logic [OFF_W-1:0] off);
    logic [ADDR_W-1:0] a;
    a        = $urandom;
    a[12]    = 1'b1;
    a[11:0]  = off;
    return a;
  endfunction

  function automatic logic [ADDR_W-1:0] console_addr(logic [CONS_AW-1:0] idx);
    logic [ADDR_W-1:0] a;
    a       = $urandom;
    a[12]   = 1'b0;
    a[9]    = 1'b0;
    a[7]    = 1'b1;
    a[6:0]  = idx;
    return a;
  endfunction

  function automatic logic [OFF_W-1:0] hot_offset();
    if ($urandom_range(0, 1) == 0) return 12'($urandom_range(12'hfe0, 12'hffb));
    return 12'($urandom_range(12'hf80, 12'hfff));
  endfunction

  function automatic logic [OFF_W-1:0] any_offset();
    if ($urandom_range(0, 3) == 0) return 12'($urandom_range(0, 12'h1ff));
    return 12'($urandom_range(0, 12'hfff));
  endfunction

  // One random sequence: mostly bank switches with reads, RAM round trips, some noise
  task automatic random_burst();
    logic [BYTE_W-1:0] idx;
    logic [ADDR_W-1:0] a;
    int                n;
    idx = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        send_beat($urandom_range(0, 1) ? KIND_WRITE : KIND_READ, cart_addr(hot_offset()),
                  8'($urandom));
        n = $urandom_range(2, 6);
        repeat (n) send_beat(KIND_READ, cart_addr(any_offset()), 8'($urandom));
      end
      3, 4: begin
        if (sb.scheme == SCHEME_F6SC) begin
          send_beat(KIND_WRITE, cart_addr({5'd0, idx[6:0]}), 8'($urandom));
          send_beat(KIND_READ, cart_addr({5'd1, idx[6:0]}), 8'($urandom));
        end else begin
          send_beat(KIND_WRITE, cart_addr({4'd0, idx}), 8'($urandom));
          send_beat(KIND_READ, cart_addr({4'd1, idx}), 8'($urandom));
        end
      end
      5: begin
        send_beat(KIND_WRITE, console_addr(idx[6:0]), 8'($urandom));
        send_beat(KIND_READ, console_addr(idx[6:0]), 8'($urandom));
      end
      6: begin
        a     = $urandom;
        a[12] = 1'b0;
        if ($urandom_range(0, 1) == 0) begin
          a[7] = 1'b0;
        end else begin
          a[9] = 1'b1;
          a[7] = 1'b1;
        end
        send_beat($urandom_range(0, 1) ? KIND_WRITE : KIND_READ, a, 8'($urandom));
      end
      7: send_beat(KIND_LOAD, 16'($urandom_range(0, 16'h7fff)), 8'($urandom));
      8: send_beat(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
      default: send_beat(KIND_READ, cart_addr(12'($urandom_range(12'hf80, 12'hfff))),
                         8'($urandom));
    endcase
  endtask

  // Fixed settings for the first random phases, extremes included
  logic [SCHEME_W-1:0] phase_scheme [8] = '{SCHEME_PLAIN, SCHEME_F8, SCHEME_F6, SCHEME_F6SC,
                                            SCHEME_E0, SCHEME_FA, SCHEME_SPARE_HI,
                                            SCHEME_SPARE_LO};
  logic [UNITS_W-1:0]  phase_units  [8] = '{4'd0, 4'd4, 4'd8, 4'd8, 4'd15, 4'd8, 4'd1, 4'd9};

  initial begin
    int unsigned target;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Decode regions, ignored writes and loads, unknown kind
    send_beat(KIND_READ,  16'h0000, 8'h00);
    send_beat(KIND_WRITE, 16'hef7f, 8'hff);
    send_beat(KIND_WRITE, 16'h00ff, 8'hff);
    send_beat(KIND_READ,  16'h00ff, 8'h00);
    send_beat(KIND_READ,  16'h0080, 8'h00);
    send_beat(KIND_READ,  16'h0280, 8'h00);
    send_beat(KIND_WRITE, 16'hefff, 8'h00);
    send_beat(KIND_READ,  16'h1000, 8'h00);
    send_beat(KIND_READ,  16'hffff, 8'h00);
    send_beat(KIND_WRITE, 16'h1234, 8'h00);
    send_beat(KIND_SPARE, 16'hffff, 8'hff);
    send_beat(KIND_LOAD,  16'hffff, 8'haa);
    send_beat(KIND_LOAD,  16'h3fff, 8'h00);

    // F8: switch on read, then on write
    reconfigure(SCHEME_F8, 4'd4);
    send_beat(KIND_READ,  16'h1ff9, 8'h00);
    send_beat(KIND_WRITE, 16'h1ff8, 8'h00);
    send_beat(KIND_READ,  16'h1000, 8'h00);

    // F6 with RAM: write window, read window, hotspot
    reconfigure(SCHEME_F6SC, 4'd8);
    send_beat(KIND_WRITE, 16'h1000, 8'h5a);
    send_beat(KIND_READ,  16'h1080, 8'h00);
    send_beat(KIND_READ,  16'h1ff6, 8'h00);

    // FA at the size above range
    reconfigure(SCHEME_FA, 4'd15);
    send_beat(KIND_WRITE, 16'h10ff, 8'ha5);
    send_beat(KIND_READ,  16'h11ff, 8'h00);
    send_beat(KIND_READ,  16'h1ffa, 8'h00);

    // E0 slices at size zero, then a mirrored small ROM under a spare scheme
    reconfigure(SCHEME_E0, 4'd0);
    send_beat(KIND_READ, 16'h1fe7, 8'h00);
    send_beat(KIND_READ, 16'h1ff7, 8'h00);
    send_beat(KIND_READ, 16'h1c00, 8'h00);
    reconfigure(SCHEME_SPARE_HI, 4'd1);
    send_beat(KIND_READ, 16'h1800, 8'h00);

    // Random phases, each under its own setting
    for (int p = 0; p < PHASES; p++) begin
      if (p < 8) reconfigure(phase_scheme[p], phase_units[p]);
      else reconfigure(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
      idle_on = (p < QUIET_PHASE) && ($urandom_range(0, 4) != 0);
      target  = sent + PHASE_BEATS;
      while (sent < target) random_burst();
    end

    drain();
    repeat (4) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
